// File: rtl/core/lfgd_pkg.sv
// Shared types and constants for the LZSS flag-group decompressor.
package lfgd_pkg;

  localparam int FLAG_GROUP = 8;
  localparam int LEN_BIAS   = 3;
  localparam int OFF_SHIFT  = 4;
  localparam logic [3:0] LEN_MASK = 4'hF;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_TRUNC_REF  = 2'd1,
    STAT_BAD_OFFSET = 2'd2,
    STAT_TRUNC_LIT  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        run_last;
    logic        stream_done;
    status_t     status;
    logic [31:0] total_bytes;
  } result_t;

  // Output buffer occupancy seen by the decoder.
  typedef struct packed {
    logic skid_busy;
    logic head_stall;
  } obuf_stat_t;

endpackage

// File: rtl/core/lfgd_hist_mem.sv
// History memory: one write port, one registered read port, write-first bypass.
module lfgd_hist_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Forward the byte written in the same cycle (offset of one).
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= mem[raddr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/lfgd_out_buf.sv
// Two-entry result buffer: output register plus skid register.
module lfgd_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lfgd_pkg::result_t   push_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lfgd_pkg::result_t   out_data,
  output lfgd_pkg::obuf_stat_t stat
);

  logic              head_valid_r;
  logic              skid_valid_r;
  lfgd_pkg::result_t head_r;
  lfgd_pkg::result_t skid_r;
  logic              head_free;

  assign head_free = !head_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (head_free) begin
      if (skid_valid_r) begin
        head_r       <= skid_r;
        head_valid_r <= 1'b1;
        skid_valid_r <= push;
        if (push) begin
          skid_r <= push_data;
        end
      end else begin
        head_valid_r <= push;
        if (push) begin
          head_r <= push_data;
        end
      end
    end else if (push) begin
      skid_r       <= push_data;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid       = head_valid_r;
  assign out_data        = head_r;
  assign stat.skid_busy  = skid_valid_r;
  assign stat.head_stall = head_valid_r && !out_ready;

endmodule

// File: rtl/core/lzss_flag_group_decompressor_unit.sv
// Top level: token decoder and copy engine of the LZSS flag-group decompressor.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | in_byte, in_stream_end
//   out_    | output    | out_valid / out_ready | out_byte, out_has_byte, out_run_last,
//           |           |                       | out_stream_done, out_status,
//           |           |                       | out_total_bytes
//
// A flag byte, low mark byte or literal is handled as it is accepted. A high mark
// byte is decoded, then starts a copy that reads one history byte per cycle, while the output
// does not stall, through the single read port of the history memory.
// Reset clears control state but not the copy registers or the history memory. in_ready
// drops while a copy or its last write is pending and while the skid register holds a
// result; out_ready low stalls the copy, never drops or repeats a byte.
module lzss_flag_group_decompressor_unit #(
  parameter int HISTORY_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_has_byte,
  output logic        out_run_last,
  output logic        out_stream_done,
  output logic [1:0]  out_status,
  output logic [31:0] out_total_bytes
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] WP_LAST = AW'(HISTORY_DEPTH - 1);

  logic [7:0]    flag_bits_r, flag_bits_nxt;
  logic [3:0]    flag_idx_r, flag_idx_nxt;
  logic          await_hi_r, await_hi_nxt;
  logic [7:0]    mark_low_r, mark_low_nxt;
  logic [31:0]   count_r, count_nxt;
  logic          drop_r, drop_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic          copy_active_r, copy_active_nxt;
  logic [4:0]    len_left_r, len_left_nxt;
  logic          copy_end_r, copy_end_nxt;
  logic          d_valid_r, d_valid_nxt;
  logic          d_last_r, d_last_nxt;

  logic                 accept;
  logic                 issue;
  logic                 is_mark;
  logic [31:0]          count_inc;
  logic [AW-1:0]        wp_inc;
  logic [AW-1:0]        rp_inc;
  logic [12:0]          offset;
  logic [AW:0]          rp_diff;
  logic [AW-1:0]        rp_start;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [7:0]           mem_wdata;
  logic [7:0]           mem_rdata;
  logic                 prod_valid;
  lfgd_pkg::result_t    prod;
  lfgd_pkg::result_t    obuf_data;
  lfgd_pkg::obuf_stat_t obuf_stat;

  assign in_ready = !copy_active_r && !d_valid_r && !obuf_stat.skid_busy;
  assign accept   = in_valid && in_ready;
  assign issue    = copy_active_r && !obuf_stat.skid_busy &&
                    !(d_valid_r && obuf_stat.head_stall);

  assign is_mark   = flag_bits_r[3'd7 - flag_idx_r[2:0]];
  assign count_inc = (&count_r) ? count_r : count_r + 32'd1;
  assign wp_inc    = (wp_r == WP_LAST) ? '0 : wp_r + AW'(1);
  assign rp_inc    = (rp_r == WP_LAST) ? '0 : rp_r + AW'(1);
  assign offset    = {1'b0, in_byte, mark_low_r[7:lfgd_pkg::OFF_SHIFT]} + 13'd1;
  assign rp_diff   = {1'b0, wp_r} - (AW+1)'(offset);
  assign rp_start  = rp_diff[AW] ? AW'(rp_diff + (AW+1)'(HISTORY_DEPTH)) : rp_diff[AW-1:0];

  always_comb begin
    flag_bits_nxt   = flag_bits_r;
    flag_idx_nxt    = flag_idx_r;
    await_hi_nxt    = await_hi_r;
    mark_low_nxt    = mark_low_r;
    count_nxt       = count_r;
    drop_nxt        = drop_r;
    wp_nxt          = wp_r;
    rp_nxt          = rp_r;
    copy_active_nxt = copy_active_r;
    len_left_nxt    = len_left_r;
    copy_end_nxt    = copy_end_r;
    d_valid_nxt     = issue;
    d_last_nxt      = d_last_r;
    mem_we          = 1'b0;
    mem_waddr       = wp_r;
    mem_wdata       = in_byte;
    prod_valid      = 1'b0;
    prod.out_byte    = 8'd0;
    prod.has_byte    = 1'b0;
    prod.run_last    = 1'b1;
    prod.stream_done = 1'b1;
    prod.status      = lfgd_pkg::STAT_OK;
    prod.total_bytes = count_r;

    // Copy engine: issue a read, then write back and emit the byte in the next cycle.
    if (issue) begin
      rp_nxt       = rp_inc;
      len_left_nxt = len_left_r - 5'd1;
      d_last_nxt   = (len_left_r == 5'd1);
      if (len_left_r == 5'd1) begin
        copy_active_nxt = 1'b0;
      end
    end

    if (d_valid_r) begin
      mem_we           = 1'b1;
      mem_wdata        = mem_rdata;
      wp_nxt           = wp_inc;
      count_nxt        = count_inc;
      prod_valid       = 1'b1;
      prod.out_byte    = mem_rdata;
      prod.has_byte    = 1'b1;
      prod.run_last    = d_last_r;
      prod.stream_done = d_last_r && copy_end_r;
      prod.total_bytes = count_inc;
    end

    if (accept) begin
      if (drop_r) begin
        // Discard until the final byte of the aborted stream.
      end else if (flag_idx_r[3]) begin
        flag_bits_nxt = in_byte;
        flag_idx_nxt  = 4'd0;
        if (in_stream_end) begin
          prod_valid  = 1'b1;
          prod.status = in_byte[7] ? lfgd_pkg::STAT_TRUNC_REF : lfgd_pkg::STAT_TRUNC_LIT;
        end
      end else if (!is_mark) begin
        mem_we           = 1'b1;
        wp_nxt           = wp_inc;
        count_nxt        = count_inc;
        flag_idx_nxt     = flag_idx_r + 4'd1;
        prod_valid       = 1'b1;
        prod.out_byte    = in_byte;
        prod.has_byte    = 1'b1;
        prod.stream_done = in_stream_end;
        prod.total_bytes = count_inc;
      end else if (!await_hi_r) begin
        mark_low_nxt = in_byte;
        await_hi_nxt = 1'b1;
        if (in_stream_end) begin
          prod_valid  = 1'b1;
          prod.status = lfgd_pkg::STAT_TRUNC_REF;
        end
      end else begin
        await_hi_nxt = 1'b0;
        flag_idx_nxt = flag_idx_r + 4'd1;
        if ({19'd0, offset} > count_r) begin
          prod_valid  = 1'b1;
          prod.status = lfgd_pkg::STAT_BAD_OFFSET;
          drop_nxt    = !in_stream_end;
        end else begin
          copy_active_nxt = 1'b1;
          rp_nxt          = rp_start;
          len_left_nxt    = {1'b0, mark_low_r[3:0] & lfgd_pkg::LEN_MASK} +
                            5'(lfgd_pkg::LEN_BIAS);
          copy_end_nxt    = in_stream_end;
        end
      end
    end

    // Start a new stream after its final byte, unless a copy still runs for it.
    if ((accept && in_stream_end && !copy_active_nxt) ||
        (d_valid_r && d_last_r && copy_end_r)) begin
      flag_bits_nxt = 8'd0;
      flag_idx_nxt  = 4'(lfgd_pkg::FLAG_GROUP);
      await_hi_nxt  = 1'b0;
      mark_low_nxt  = 8'd0;
      count_nxt     = 32'd0;
      drop_nxt      = 1'b0;
      wp_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_bits_r   <= 8'd0;
      flag_idx_r    <= 4'(lfgd_pkg::FLAG_GROUP);
      await_hi_r    <= 1'b0;
      mark_low_r    <= 8'd0;
      count_r       <= 32'd0;
      drop_r        <= 1'b0;
      wp_r          <= '0;
      copy_active_r <= 1'b0;
      d_valid_r     <= 1'b0;
      copy_end_r    <= 1'b0;
    end else begin
      flag_bits_r   <= flag_bits_nxt;
      flag_idx_r    <= flag_idx_nxt;
      await_hi_r    <= await_hi_nxt;
      mark_low_r    <= mark_low_nxt;
      count_r       <= count_nxt;
      drop_r        <= drop_nxt;
      wp_r          <= wp_nxt;
      copy_active_r <= copy_active_nxt;
      d_valid_r     <= d_valid_nxt;
      copy_end_r    <= copy_end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rp_r       <= rp_nxt;
    len_left_r <= len_left_nxt;
    d_last_r   <= d_last_nxt;
  end

  lfgd_hist_mem #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (issue),
    .raddr (rp_r),
    .rdata (mem_rdata)
  );

  lfgd_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (prod_valid),
    .push_data (prod),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (obuf_data),
    .stat      (obuf_stat)
  );

  assign out_byte        = obuf_data.out_byte;
  assign out_has_byte    = obuf_data.has_byte;
  assign out_run_last    = obuf_data.run_last;
  assign out_stream_done = obuf_data.stream_done;
  assign out_status      = obuf_data.status;
  assign out_total_bytes = obuf_data.total_bytes;

endmodule

// File: rtl/core/lfgd_checker.sv
// Port-level checks for the decompressor, bound to the top level.
module lfgd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_byte,
  input logic        in_stream_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_has_byte,
  input logic        out_run_last,
  input logic        out_stream_done,
  input logic [1:0]  out_status,
  input logic [31:0] out_total_bytes
);

  // A status-only result always ends the stream with an error code.
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |->
      out_stream_done && out_run_last && (out_status != lfgd_pkg::STAT_OK))
    else $error("status-only result without error end");

  // Data bytes carry an ok status.
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_byte |-> out_status == lfgd_pkg::STAT_OK)
    else $error("data result with error status");

  // A stream can only finish on the last result of an input byte.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_done |-> out_run_last)
    else $error("stream done before last result of input byte");

  // No result right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind lzss_flag_group_decompressor_unit lfgd_checker u_lfgd_checker (.*);

// File: tb/sv/lzss_flag_group_decompressor_unit_test.sv
// Self-checking testbench for the LZSS flag-group decompressor: driver, model, monitor.
module lzss_flag_group_decompressor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 9;
  localparam int HIST_DEPTH    = 4096;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int RANDOM_ITEMS  = 100;
  localparam int HOLD_AFTER    = 150;
  localparam int HOLD_CYCLES   = 400;

  typedef enum logic [1:0] {ITEM_BYTE, ITEM_DRAIN, ITEM_QUIET} item_kind_t;
  typedef enum logic [1:0] {END_NORMAL, END_ON_FLAG, END_ON_LOW, END_BAD_OFFSET} end_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic [7:0] data;
    logic       last;
  } stream_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        in_stream_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_has_byte;
  logic        out_run_last;
  logic        out_stream_done;
  logic [1:0]  out_status;
  logic [31:0] out_total_bytes;

  stream_item_t        byte_q[$];
  lfgd_pkg::result_t   expected_q[$];
  int           item_count = 0;
  int           fail_count = 0;
  int           results_seen = 0;
  int           cycle_count = 0;
  int           send_gap = 0;
  int           recv_gap = 0;
  int           long_hold = 0;
  bit           hold_done = 1'b0;
  bit           quiet = 1'b0;

  // Decoder state mirrored from the block
  logic [7:0]  dec_hist [0:HIST_DEPTH-1];
  logic [7:0]  dec_flags = 8'h00;
  int          dec_fidx = lfgd_pkg::FLAG_GROUP;
  bit          dec_await = 1'b0;
  logic [7:0]  dec_mlo = 8'h00;
  logic [31:0] dec_count = 32'd0;
  bit          dec_drop = 1'b0;
  int unsigned dec_wpos = 0;

  lzss_flag_group_decompressor_unit #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_stream_end  (in_stream_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_has_byte   (out_has_byte),
    .out_run_last   (out_run_last),
    .out_stream_done(out_stream_done),
    .out_status     (out_status),
    .out_total_bytes(out_total_bytes)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic lfgd_pkg::result_t make_result(input logic [7:0] b, input logic has,
                                                    input logic last, input logic done,
                                                    input lfgd_pkg::status_t st);
    lfgd_pkg::result_t r;
    r.out_byte    = b;
    r.has_byte    = has;
    r.run_last    = last;
    r.stream_done = done;
    r.status      = st;
    r.total_bytes = dec_count;
    return r;
  endfunction

  task automatic restart_stream();
    dec_flags = 8'h00;
    dec_fidx  = lfgd_pkg::FLAG_GROUP;
    dec_await = 1'b0;
    dec_mlo   = 8'h00;
    dec_count = 32'd0;
    dec_drop  = 1'b0;
    dec_wpos  = 0;
  endtask

  task automatic append_history(input logic [7:0] b);
    dec_hist[dec_wpos] = b;
    dec_wpos = (dec_wpos + 1) % HIST_DEPTH;
    if (dec_count != 32'hFFFF_FFFF) dec_count++;
  endtask

  // Expected results of one compressed byte
  task automatic decode_byte(input logic [7:0] b, input logic e);
    logic [15:0] word;
    int unsigned off;
    int unsigned len;
    int unsigned i;
    logic [7:0]  v;
    if (dec_drop) begin
      if (e) restart_stream();
      return;
    end
    if (dec_fidx >= lfgd_pkg::FLAG_GROUP) begin
      dec_flags = b;
      dec_fidx = 0;
      if (e) begin
        expected_q.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b1,
                                         b[7] ? lfgd_pkg::STAT_TRUNC_REF :
                                                lfgd_pkg::STAT_TRUNC_LIT));
        restart_stream();
      end
      return;
    end
    if (!dec_flags[7 - dec_fidx]) begin
      append_history(b);
      expected_q.push_back(make_result(b, 1'b1, 1'b1, e, lfgd_pkg::STAT_OK));
      dec_fidx++;
    end else if (!dec_await) begin
      dec_mlo = b;
      dec_await = 1'b1;
      if (e) begin
        expected_q.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b1,
                                         lfgd_pkg::STAT_TRUNC_REF));
        restart_stream();
      end
      return;
    end else begin
      word = {b, dec_mlo};
      off = int'(word[15:lfgd_pkg::OFF_SHIFT]) + 1;
      len = int'(word[3:0] & lfgd_pkg::LEN_MASK) + lfgd_pkg::LEN_BIAS;
      dec_await = 1'b0;
      dec_fidx++;
      if (off > dec_count) begin
        expected_q.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b1,
                                         lfgd_pkg::STAT_BAD_OFFSET));
        if (e) restart_stream();
        else dec_drop = 1'b1;
        return;
      end
      for (i = 0; i < len; i++) begin
        v = dec_hist[(dec_wpos + HIST_DEPTH - off) % HIST_DEPTH];
        append_history(v);
        expected_q.push_back(make_result(v, 1'b1, i == len - 1, (i == len - 1) && e,
                                         lfgd_pkg::STAT_OK));
      end
    end
    if (e) restart_stream();
  endtask

  task automatic add_byte(input logic [7:0] b, input logic e);
    stream_item_t it;
    it.kind = ITEM_BYTE;
    it.data = b;
    it.last = e;
    byte_q.push_back(it);
    item_count++;
  endtask

  task automatic add_marker(input item_kind_t k);
    stream_item_t it;
    it.kind = k;
    it.data = 8'h00;
    it.last = 1'b0;
    byte_q.push_back(it);
  endtask

  // Well-formed stream of ntok tokens with the chosen way of ending
  task automatic build_stream(input int ntok, input end_kind_t ending, input int off_cap,
                              input int mark_pct, input int len_lo);
    int         produced;
    int         t;
    int         j;
    int         glen;
    int         off;
    int         len;
    int         tail;
    logic [7:0] flags;
    logic [15:0] word;
    logic [7:0] grp[$];
    bit         mk;
    bit         final_tok;
    bit         end_here;
    produced = 0;
    t = 0;
    if (ending == END_ON_FLAG) ntok = (ntok / lfgd_pkg::FLAG_GROUP) * lfgd_pkg::FLAG_GROUP;
    else if (ntok < 1) ntok = 1;
    tail = (ending == END_BAD_OFFSET) ? $urandom_range(0, 4) : 0;
    end_here = (ending != END_ON_FLAG) && (tail == 0);
    while (t < ntok) begin
      glen = (ntok - t < lfgd_pkg::FLAG_GROUP) ? ntok - t : lfgd_pkg::FLAG_GROUP;
      flags = 8'($urandom);
      grp.delete();
      for (j = 0; j < glen; j++) begin
        final_tok = (t + j == ntok - 1);
        mk = ($urandom_range(0, 99) < mark_pct);
        if (final_tok && (ending == END_ON_LOW || ending == END_BAD_OFFSET)) mk = 1'b1;
        else if (produced == 0) mk = 1'b0;
        flags[7 - j] = mk;
        if (!mk) begin
          grp.push_back(8'($urandom));
          produced++;
        end else begin
          len = $urandom_range(len_lo, 18);
          if (final_tok && ending == END_BAD_OFFSET && produced < HIST_DEPTH)
            off = $urandom_range(0, 1) ? produced + 1 : $urandom_range(produced + 1, HIST_DEPTH);
          else if (produced >= off_cap && $urandom_range(0, 3) == 0)
            off = off_cap;
          else
            off = $urandom_range(1, (produced < off_cap) ? produced : off_cap);
          if (off < 1) off = 1;
          word = 16'(((off - 1) << lfgd_pkg::OFF_SHIFT) | (len - lfgd_pkg::LEN_BIAS));
          grp.push_back(word[7:0]);
          if (!(final_tok && ending == END_ON_LOW)) grp.push_back(word[15:8]);
          if (off <= produced) produced += len;
        end
      end
      add_byte(flags, 1'b0);
      foreach (grp[k])
        add_byte(grp[k], end_here && (t + glen == ntok) && (k == grp.size() - 1));
      t += glen;
    end
    if (ending == END_ON_FLAG) add_byte(8'($urandom), 1'b1);
    for (j = 0; j < tail; j++) add_byte(8'($urandom), j == tail - 1);
  endtask

  task automatic random_streams(input int target);
    int        pick;
    int        n;
    int        j;
    end_kind_t ending;
    while (item_count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // raw noise; the last byte closes whatever stream it left open
        n = $urandom_range(1, 12);
        for (j = 0; j < n; j++)
          add_byte(8'($urandom), (j == n - 1) || ($urandom_range(0, 5) == 0));
      end else begin
        if (pick < 60) ending = END_NORMAL;
        else if (pick < 72) ending = END_ON_FLAG;
        else if (pick < 84) ending = END_ON_LOW;
        else ending = END_BAD_OFFSET;
        build_stream(($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 20),
                     ending, $urandom_range(0, 1) ? 8 : HIST_DEPTH, $urandom_range(20, 80), 3);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Driver: present pending bytes, predict on each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_byte(in_byte, in_stream_end);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (byte_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (byte_q[0].kind == ITEM_DRAIN) begin
          // hold until every expected result is out
          in_valid <= 1'b0;
          if (expected_q.size() == 0) void'(byte_q.pop_front());
        end else if (byte_q[0].kind == ITEM_QUIET) begin
          quiet = 1'b1;
          in_valid <= 1'b0;
          void'(byte_q.pop_front());
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_byte <= byte_q[0].data;
          in_stream_end <= byte_q[0].last;
          void'(byte_q.pop_front());
        end
      end
    end
  end

  // Monitor: compare every result transfer with the oldest expectation
  always @(posedge clk) begin
    lfgd_pkg::result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("unexpected result: byte 0x%0h status %0d", out_byte, out_status);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("out_byte", 32'(want.out_byte), 32'(out_byte));
          check_field("out_has_byte", 32'(want.has_byte), 32'(out_has_byte));
          check_field("out_run_last", 32'(want.run_last), 32'(out_run_last));
          check_field("out_stream_done", 32'(want.stream_done), 32'(out_stream_done));
          check_field("out_status", 32'(want.status), 32'(out_status));
          check_field("out_total_bytes", want.total_bytes, out_total_bytes);
        end
      end
      if (long_hold > 0) begin
        long_hold--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        // back up the block while the driver keeps offering bytes
        hold_done = 1'b1;
        long_hold = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        recv_gap = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    // stream ends on a flag byte: mark first, then literal first
    add_byte(8'h80, 1'b1);
    add_byte(8'h00, 1'b1);
    // two literals at the byte extremes, normal end on a literal
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    // overlapping copy: offset 1, length 18, normal end on a mark
    add_byte(8'h40, 1'b0);
    add_byte(8'hA5, 1'b0);
    add_byte(8'h0F, 1'b0);
    add_byte(8'h00, 1'b1);
    // offset before stream start, then drop until the closing byte
    add_byte(8'h80, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h12, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b1);
    // stream ends on a low mark byte
    add_byte(8'h40, 1'b0);
    add_byte(8'h5A, 1'b0);
    add_byte(8'h33, 1'b1);
    // largest offset with too little history, ending on the same byte
    add_byte(8'h40, 1'b0);
    add_byte(8'hC3, 1'b0);
    add_byte(8'hF0, 1'b0);
    add_byte(8'hFF, 1'b1);
    // offset equal to the bytes so far, unused flag bits left over
    add_byte(8'h2A, 1'b0);
    add_byte(8'h11, 1'b0);
    add_byte(8'h22, 1'b0);
    add_byte(8'h10, 1'b0);
    add_byte(8'h00, 1'b1);
    add_marker(ITEM_DRAIN);
    random_streams(item_count + RANDOM_ITEMS / 2);
    add_marker(ITEM_DRAIN);
    // one long stream so history wraps and the largest offset is legal
    build_stream(240, END_NORMAL, HIST_DEPTH, 100, 18);
    random_streams(item_count + RANDOM_ITEMS / 4);
    add_marker(ITEM_QUIET);
    random_streams(item_count + RANDOM_ITEMS / 4);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    while (byte_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: lzss_flag_group_decompressor_unit.f
rtl/core/lfgd_pkg.sv
rtl/core/lfgd_hist_mem.sv
rtl/core/lfgd_out_buf.sv
rtl/core/lzss_flag_group_decompressor_unit.sv
rtl/core/lfgd_checker.sv
tb/sv/lzss_flag_group_decompressor_unit_test.sv
